>>> src/rtumfb_pkg.sv
`timescale 1ns / 1ps

package rtumfb_pkg;

    // request frame layout
    localparam int REQUEST_BYTES = 8;
    localparam int HEADER_BYTES  = 6;
    localparam int IDX_W         = $clog2(REQUEST_BYTES);

    // crc-16 as used on the rtu line (reflected)
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // function codes
    localparam logic [2:0] FC_READ_COILS      = 3'd1;
    localparam logic [2:0] FC_READ_INPUTS     = 3'd2;
    localparam logic [2:0] FC_READ_HOLDING    = 3'd3;
    localparam logic [2:0] FC_READ_INPUT_REGS = 3'd4;
    localparam logic [2:0] FC_FORCE_COIL      = 3'd5;

    // coil value high byte for force coil on
    localparam logic [7:0] COIL_ON_HI = 8'hFF;

    typedef logic [7:0] byte_t;

    // kind of an output transfer
    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_STATUS  = 2'd2
    } kind_t;

    // one result group handed to the output stage
    typedef struct packed {
        logic  req;
        kind_t kind;
        byte_t data;
        logic  status;
    } grp_load_t;

    // frame crc written back once the header has gone out
    typedef struct packed {
        logic        valid;
        logic [15:0] crc;
    } crc_wr_t;

    // byte-wide crc update, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input byte_t b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> src/rtumfb_out.sv
`timescale 1ns / 1ps

module rtumfb_out (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              load,
    input  rtumfb_pkg::grp_load_t                             load_info,
    input  logic [rtumfb_pkg::HEADER_BYTES-1:0][7:0]          head,
    output logic                                              free,
    output rtumfb_pkg::crc_wr_t                               crc_wr,
    output logic                                              m_tvalid,
    input  logic                                              m_tready,
    output logic [15:0]                                       m_tdata,  // data_byte, status, pad
    output logic [1:0]                                        m_tuser,  // kind
    output logic                                              m_tlast
);
    import rtumfb_pkg::*;

    logic                             grp_valid_reg;
    logic                             grp_req_reg;
    logic [IDX_W-1:0]                 idx_reg;
    kind_t                            kind_reg;
    byte_t                            data_reg;
    logic                             status_reg;
    logic [HEADER_BYTES-1:0][7:0]     shift_reg;
    logic [15:0]                      crc_reg;

    logic                             xfer;
    logic                             burst_end;
    logic                             in_head;
    logic [15:0]                      crc_step;
    byte_t                            req_byte;

    // transfer bookkeeping
    assign xfer      = grp_valid_reg && m_tready;
    assign burst_end = grp_req_reg ? (idx_reg == IDX_W'(REQUEST_BYTES - 1)) : 1'b1;
    assign free      = !grp_valid_reg || (xfer && burst_end);
    assign in_head   = idx_reg < IDX_W'(HEADER_BYTES);

    // frame crc runs over the header bytes as they leave
    assign crc_step      = crc_byte(crc_reg, shift_reg[0]);
    assign crc_wr.valid  = xfer && grp_req_reg && (idx_reg == IDX_W'(HEADER_BYTES - 1));
    assign crc_wr.crc    = crc_step;

    // request byte select: header, then crc low, then crc high
    always_comb
    begin
        if (in_head)
        begin
            req_byte = shift_reg[0];
        end
        else if (idx_reg == IDX_W'(HEADER_BYTES))
        begin
            req_byte = crc_reg[7:0];
        end
        else
        begin
            req_byte = crc_reg[15:8];
        end
    end

    // output port
    assign m_tvalid = grp_valid_reg;
    assign m_tuser  = grp_req_reg ? KIND_REQUEST : kind_reg;
    assign m_tdata  = {7'b0, (grp_req_reg ? 1'b0 : status_reg),
                       (grp_req_reg ? req_byte : data_reg)};
    assign m_tlast  = grp_req_reg ? burst_end : (kind_reg == KIND_STATUS);

    // group control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                grp_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (xfer)
            begin
                grp_valid_reg <= !burst_end;
                idx_reg       <= idx_reg + 1'b1;
            end
        end
    end

    // group payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_req_reg <= load_info.req;
            kind_reg    <= load_info.kind;
            data_reg    <= load_info.data;
            status_reg  <= load_info.status;
            shift_reg   <= head;
            crc_reg     <= CRC_INIT;
        end
        else if (xfer && grp_req_reg && in_head)
        begin
            shift_reg <= {8'h00, shift_reg[HEADER_BYTES-1:1]};
            crc_reg   <= crc_step;
        end
    end

endmodule

>>> src/rtu_master_frame_builder_checker_top.sv
`timescale 1ns / 1ps

// Modbus rtu master framer and reply checker.
// Input channel s_*: one item per transfer. tuser selects a request (0) or one
// received reply byte (1). A request with function 1 to 5 sends its 8-byte frame
// (crc low byte first) on m_*, kind 0, tlast on the eighth byte, and arms the
// reply checker. Reply bytes are checked against slave, function and crc (or the
// full echo for function 5); payload bytes go out as kind 1, and after the last
// expected byte a kind 2 item with tlast carries the status bit.
// An input item passes the input register, then the result register, before
// its first result appears on m_*.
// Reply bytes are taken one after another while the output stage is free; a
// request holds the output stage until all eight frame bytes have gone out, and
// the frame crc is folded in byte by byte as the header leaves.
// An input register and the result stage are decoupled, so a new item is taken
// while a finished result still waits on m_tready. When the receiver stalls,
// the result stage holds and one more item waits in the input register.
// Reset clears all control and checker state; no reply is expected afterwards.

module rtu_master_frame_builder_checker_top #(
    parameter int MAX_REPLY_BYTES = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // slave_id, function_code, start_address,
                                   // quantity, coil_on, rx_byte, pad
    input  logic [0:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // data_byte, status, pad
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);
    import rtumfb_pkg::*;

    localparam int LEN_W         = $clog2(MAX_REPLY_BYTES + 1);
    localparam int RAW_W         = 13;
    localparam int PAYLOAD_FIRST = 3;

    // input register
    logic         in_valid_reg;
    logic         in_mode_reg;
    byte_t        in_slave_reg;
    logic [2:0]   in_fc_reg;
    logic [15:0]  in_start_reg;
    logic [10:0]  in_qty_reg;
    logic         in_coil_reg;
    byte_t        in_rx_reg;

    // request and reply state
    byte_t             sent_frame_reg [REQUEST_BYTES];
    logic [LEN_W-1:0]  expected_len_reg;
    logic [LEN_W-1:0]  byte_cnt_reg;
    logic [15:0]       run_crc_reg;
    logic              mismatch_reg;
    logic              awaiting_reg;

    logic [LEN_W-1:0]  expected_len_next;
    logic [LEN_W-1:0]  byte_cnt_next;
    logic [15:0]       run_crc_next;
    logic              mismatch_next;
    logic              awaiting_next;

    logic                          fire;
    logic                          fc_ok;
    logic                          req_fire;
    logic                          rep_fire;
    logic                          out_free;
    logic                          out_load;
    grp_load_t                     load_info;
    crc_wr_t                       crc_wr;
    logic [HEADER_BYTES-1:0][7:0]  head;
    logic [RAW_W-1:0]              len_raw;
    logic [LEN_W-1:0]              len_sat;
    logic                          echo;
    byte_t                         frame_b;
    logic [LEN_W:0]                pos_plus2;
    logic                          in_body;
    logic                          at_crc_lo;
    logic                          forward;
    logic                          done;
    logic                          bad;

    // handshake
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb
    begin
        case (in_fc_reg) inside
            [FC_READ_COILS:FC_FORCE_COIL]: fc_ok = 1'b1;
            default:                       fc_ok = 1'b0;
        endcase
    end

    assign req_fire = fire && !in_mode_reg && fc_ok;
    assign rep_fire = fire && in_mode_reg && awaiting_reg;

    // request header bytes
    always_comb
    begin
        head[0] = in_slave_reg;
        head[1] = {5'b0, in_fc_reg};
        head[2] = in_start_reg[15:8];
        head[3] = in_start_reg[7:0];
        if (in_fc_reg == FC_FORCE_COIL)
        begin
            head[4] = in_coil_reg ? COIL_ON_HI : 8'h00;
            head[5] = 8'h00;
        end
        else
        begin
            head[4] = {5'b0, in_qty_reg[10:8]};
            head[5] = in_qty_reg[7:0];
        end
    end

    // expected reply length, saturated
    always_comb
    begin
        if (in_fc_reg == FC_FORCE_COIL)
        begin
            len_raw = RAW_W'(REQUEST_BYTES);
        end
        else if (in_fc_reg == FC_READ_COILS || in_fc_reg == FC_READ_INPUTS)
        begin
            len_raw = ((RAW_W'(in_qty_reg) + RAW_W'(7)) >> 3) + RAW_W'(5);
        end
        else
        begin
            len_raw = (RAW_W'(in_qty_reg) << 1) + RAW_W'(5);
        end
        if (len_raw > RAW_W'(MAX_REPLY_BYTES))
        begin
            len_sat = LEN_W'(MAX_REPLY_BYTES);
        end
        else
        begin
            len_sat = len_raw[LEN_W-1:0];
        end
    end

    // reply byte checks
    assign echo      = (sent_frame_reg[1] == {5'b0, FC_FORCE_COIL});
    assign frame_b   = sent_frame_reg[byte_cnt_reg[IDX_W-1:0]];
    assign pos_plus2 = {1'b0, byte_cnt_reg} + (LEN_W+1)'(2);
    assign in_body   = pos_plus2 < {1'b0, expected_len_reg};
    assign at_crc_lo = pos_plus2 == {1'b0, expected_len_reg};
    assign forward   = in_body && !echo && (byte_cnt_reg >= LEN_W'(PAYLOAD_FIRST));

    always_comb
    begin
        bad = 1'b0;
        if (echo)
        begin
            if (byte_cnt_reg < LEN_W'(REQUEST_BYTES) && in_rx_reg != frame_b)
            begin
                bad = 1'b1;
            end
        end
        else if (byte_cnt_reg < LEN_W'(2) && in_rx_reg != frame_b)
        begin
            bad = 1'b1;
        end
        if (at_crc_lo && in_rx_reg != run_crc_reg[7:0])
        begin
            bad = 1'b1;
        end
        if (!in_body && !at_crc_lo && in_rx_reg != run_crc_reg[15:8])
        begin
            bad = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        expected_len_next = expected_len_reg;
        byte_cnt_next     = byte_cnt_reg;
        run_crc_next      = run_crc_reg;
        mismatch_next     = mismatch_reg;
        awaiting_next     = awaiting_reg;
        done              = 1'b0;
        if (req_fire)
        begin
            expected_len_next = len_sat;
            byte_cnt_next     = '0;
            run_crc_next      = CRC_INIT;
            mismatch_next     = 1'b0;
            awaiting_next     = 1'b1;
        end
        else if (rep_fire)
        begin
            byte_cnt_next = byte_cnt_reg + 1'b1;
            mismatch_next = mismatch_reg | bad;
            if (in_body)
            begin
                run_crc_next = crc_byte(run_crc_reg, in_rx_reg);
            end
            done = byte_cnt_next >= expected_len_reg;
            if (done)
            begin
                awaiting_next = 1'b0;
            end
        end
    end

    // result group for the output stage
    always_comb
    begin
        load_info.req    = !in_mode_reg;
        load_info.kind   = KIND_REQUEST;
        load_info.data   = in_rx_reg;
        load_info.status = 1'b0;
        out_load         = req_fire;
        if (rep_fire && done)
        begin
            load_info.kind   = KIND_STATUS;
            load_info.data   = 8'h00;
            load_info.status = mismatch_next;
            out_load         = 1'b1;
        end
        else if (rep_fire && forward)
        begin
            load_info.kind = KIND_PAYLOAD;
            out_load       = 1'b1;
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg  <= s_tuser[0];
            in_slave_reg <= s_tdata[7:0];
            in_fc_reg    <= s_tdata[10:8];
            in_start_reg <= s_tdata[26:11];
            in_qty_reg   <= s_tdata[37:27];
            in_coil_reg  <= s_tdata[38];
            in_rx_reg    <= s_tdata[46:39];
        end
    end

    // checker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_len_reg <= '0;
            byte_cnt_reg     <= '0;
            run_crc_reg      <= CRC_INIT;
            mismatch_reg     <= 1'b0;
            awaiting_reg     <= 1'b0;
        end
        else
        begin
            expected_len_reg <= expected_len_next;
            byte_cnt_reg     <= byte_cnt_next;
            run_crc_reg      <= run_crc_next;
            mismatch_reg     <= mismatch_next;
            awaiting_reg     <= awaiting_next;
        end
    end

    // kept request frame: header at request, crc once it is known
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            for (int i = 0; i < HEADER_BYTES; i++)
            begin
                sent_frame_reg[i] <= head[i];
            end
        end
        if (crc_wr.valid)
        begin
            sent_frame_reg[HEADER_BYTES]     <= crc_wr.crc[7:0];
            sent_frame_reg[HEADER_BYTES + 1] <= crc_wr.crc[15:8];
        end
    end

    rtumfb_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_info (load_info),
        .head      (head),
        .free      (out_free),
        .crc_wr    (crc_wr),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // input side only stalls while an item is held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // an armed checker has not yet reached the reply length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> (byte_cnt_reg < expected_len_reg))
        else $error("reply counter reached length while armed");

    // a valid request arms a fresh reply check
    a_request_arms: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (awaiting_reg && byte_cnt_reg == '0 && !mismatch_reg))
        else $error("request did not arm the reply checker");

    // payload transfers carry no status and no end mark
    a_payload_plain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_PAYLOAD) |-> (!m_tlast && !m_tdata[8]))
        else $error("payload transfer with status or tlast");
`endif

endmodule

>>> tb/sv/rtu_frame_checker.sv
`timescale 1ns / 1ps

module rtu_frame_checker #(
    parameter int MAX_REPLY = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // slave_id, function_code, start_address,
                                   // quantity, coil_on, rx_byte, pad
    input  logic [0:0]  s_tuser,   // mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // data_byte, status, pad
    input  logic [1:0]  m_tuser,   // kind
    input  logic        m_tlast,
    output int          mismatches,
    output int          outstanding,
    output int          checked
);
    import rtumfb_pkg::*;

    // one transfer on the master side
    typedef struct packed {
        kind_t kind;
        byte_t data;
        logic  status;
        logic  last;
    } out_item_t;

    out_item_t   due_items[$];

    // mirror of the master state
    byte_t       req_frame[REQUEST_BYTES];
    int          reply_len;
    int          reply_pos;
    logic [15:0] reply_crc;
    logic        reply_bad;
    logic        reply_armed;

    int          err_count = 0;
    int          ok_count  = 0;

    // reflected crc-16, one byte
    function automatic logic [15:0] crc16_fold(logic [15:0] crc, byte_t b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        repeat (8)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic void note_mismatch(string what);
        err_count++;
        if (err_count <= 10)
        begin
            $display("%0t mismatch: %s", $realtime, what);
        end
    endfunction

    // request with function 1 to 5: build the frame, arm the reply check, queue eight frame bytes
    function automatic void predict_request(logic [47:0] d);
        logic [2:0]  fc;
        logic [10:0] qty;
        logic [15:0] crc;
        int          n;
        fc  = d[10:8];
        qty = d[37:27];
        if (fc < FC_READ_COILS || fc > FC_FORCE_COIL)
        begin
            return;
        end
        req_frame[0] = d[7:0];
        req_frame[1] = {5'd0, fc};
        req_frame[2] = d[26:19];
        req_frame[3] = d[18:11];
        if (fc == FC_FORCE_COIL)
        begin
            req_frame[4] = d[38] ? 8'hFF : 8'h00;
            req_frame[5] = 8'h00;
            n = 8;
        end
        else
        begin
            req_frame[4] = {5'd0, qty[10:8]};
            req_frame[5] = qty[7:0];
            if (fc <= FC_READ_INPUTS)
            begin
                n = (int'(qty) + 7) / 8 + 5;
            end
            else
            begin
                n = 2 * int'(qty) + 5;
            end
        end
        crc = 16'hFFFF;
        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            crc = crc16_fold(crc, req_frame[i]);
        end
        req_frame[6] = crc[7:0];
        req_frame[7] = crc[15:8];
        reply_len   = (n > MAX_REPLY) ? MAX_REPLY : n;
        reply_pos   = 0;
        reply_crc   = 16'hFFFF;
        reply_bad   = 1'b0;
        reply_armed = 1'b1;
        for (int i = 0; i < REQUEST_BYTES; i++)
        begin
            due_items.push_back(out_item_t'{KIND_REQUEST, req_frame[i], 1'b0,
                                            i == REQUEST_BYTES - 1});
        end
    endfunction

    // reply byte: header or echo compare, crc, payload forward, final status
    function automatic void predict_reply_byte(byte_t b);
        logic echo;
        if (!reply_armed)
        begin
            return;
        end
        echo = (req_frame[1] == {5'd0, FC_FORCE_COIL});
        if (echo)
        begin
            if (reply_pos < REQUEST_BYTES && b != req_frame[reply_pos])
            begin
                reply_bad = 1'b1;
            end
        end
        else if ((reply_pos == 0 && b != req_frame[0]) ||
                 (reply_pos == 1 && b != req_frame[1]))
        begin
            reply_bad = 1'b1;
        end
        if (reply_pos + 2 < reply_len)
        begin
            reply_crc = crc16_fold(reply_crc, b);
            if (!echo && reply_pos >= 3)
            begin
                due_items.push_back(out_item_t'{KIND_PAYLOAD, b, 1'b0, 1'b0});
            end
        end
        else if (reply_pos + 2 == reply_len)
        begin
            if (b != reply_crc[7:0])
            begin
                reply_bad = 1'b1;
            end
        end
        else if (b != reply_crc[15:8])
        begin
            reply_bad = 1'b1;
        end
        reply_pos++;
        if (reply_pos >= reply_len)
        begin
            due_items.push_back(out_item_t'{KIND_STATUS, 8'h00, reply_bad, 1'b1});
            reply_armed = 1'b0;
        end
    endfunction

    // compare one master transfer with the oldest prediction
    function automatic void check_result();
        out_item_t got;
        out_item_t want;
        got = out_item_t'{kind_t'(m_tuser), m_tdata[7:0], m_tdata[8], m_tlast};
        if (due_items.size() == 0)
        begin
            note_mismatch($sformatf(
                "unexpected transfer kind=%0d data=%02h status=%0b last=%0b",
                got.kind, got.data, got.status, got.last));
            return;
        end
        want = due_items.pop_front();
        if (got.kind !== want.kind || got.data !== want.data ||
            got.status !== want.status || got.last !== want.last)
        begin
            note_mismatch($sformatf(
                {"exp kind=%0d data=%02h status=%0b last=%0b, ",
                 "got kind=%0d data=%02h status=%0b last=%0b"},
                want.kind, want.data, want.status, want.last,
                got.kind, got.data, got.status, got.last));
        end
        else
        begin
            ok_count++;
        end
    endfunction

    // watch both channels; output side first so a same-edge input cannot match
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_items.delete();
            foreach (req_frame[i])
            begin
                req_frame[i] = 8'h00;
            end
            reply_len   = 0;
            reply_pos   = 0;
            reply_crc   = 16'hFFFF;
            reply_bad   = 1'b0;
            reply_armed = 1'b0;
            outstanding <= 0;
            mismatches  <= 0;
            checked     <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_result();
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0])
                begin
                    predict_reply_byte(s_tdata[46:39]);
                end
                else
                begin
                    predict_request(s_tdata);
                end
            end
            outstanding <= due_items.size();
            mismatches  <= err_count;
            checked     <= ok_count;
        end
    end

endmodule

>>> tb/sv/tb_rtu_master_frame_builder_checker_top.sv
`timescale 1ns / 1ps

module tb_rtu_master_frame_builder_checker_top;
    import rtumfb_pkg::*;

    localparam int MAX_REPLY      = 255;
    localparam int TARGET_ITEMS   = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int          mismatches;
    int          outstanding;
    int          checked;

    // stimulus side view of the open request
    byte_t       tx_frame[REQUEST_BYTES];
    int          reply_len = 0;
    int          reply_pos = 0;
    logic        reply_open = 1'b0;

    int          work_items = 0;
    int          requests = 0;
    int          reply_bytes = 0;
    int          ignored = 0;
    logic        steady = 1'b0;
    int          stall_left = 0;
    int          idle_cycles = 0;

    rtu_master_frame_builder_checker_top #(
        .MAX_REPLY_BYTES(MAX_REPLY)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    rtu_frame_checker #(
        .MAX_REPLY(MAX_REPLY)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .outstanding(outstanding),
        .checked    (checked)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // mostly short pauses, now and then a long one
    function automatic int pause_len();
        if ($urandom_range(0, 99) < 85)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [47:0] pack_item(byte_t slave, logic [2:0] fc,
                                              logic [15:0] addr, logic [10:0] qty,
                                              logic coil, byte_t rx);
        return {1'b0, rx, coil, qty, addr, fc, slave};
    endfunction

    function automatic logic [10:0] pick_quantity(logic [2:0] fc);
        if (fc == FC_FORCE_COIL || $urandom_range(0, 39) == 0)
        begin
            return 11'($urandom);
        end
        if (fc <= FC_READ_INPUTS)
        begin
            return 11'($urandom_range(0, 40));
        end
        return 11'($urandom_range(0, 6));
    endfunction

    // one slave-side transfer, with an optional gap in front
    task automatic push_item(logic mode, logic [47:0] d);
        int gap;
        gap = (steady || $urandom_range(0, 99) < 55) ? 0 : pause_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= mode;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    task automatic send_request(byte_t slave, logic [2:0] fc, logic [15:0] addr,
                                logic [10:0] qty, logic coil);
        logic [15:0] crc;
        int          n;
        if (fc >= FC_READ_COILS && fc <= FC_FORCE_COIL)
        begin
            tx_frame[0] = slave;
            tx_frame[1] = {5'd0, fc};
            tx_frame[2] = addr[15:8];
            tx_frame[3] = addr[7:0];
            if (fc == FC_FORCE_COIL)
            begin
                tx_frame[4] = coil ? COIL_ON_HI : 8'h00;
                tx_frame[5] = 8'h00;
                n = 8;
            end
            else
            begin
                tx_frame[4] = {5'd0, qty[10:8]};
                tx_frame[5] = qty[7:0];
                n = (fc <= FC_READ_INPUTS) ? (int'(qty) + 7) / 8 + 5 : 2 * int'(qty) + 5;
            end
            crc = CRC_INIT;
            for (int i = 0; i < HEADER_BYTES; i++)
            begin
                crc = crc_byte(crc, tx_frame[i]);
            end
            tx_frame[6] = crc[7:0];
            tx_frame[7] = crc[15:8];
            reply_len  = (n > MAX_REPLY) ? MAX_REPLY : n;
            reply_pos  = 0;
            reply_open = 1'b1;
            work_items++;
            requests++;
        end
        else
        begin
            ignored++;
        end
        push_item(1'b0, pack_item(slave, fc, addr, qty, coil, byte_t'($urandom)));
    endtask

    // reply byte; the request-side fields carry noise
    task automatic send_reply_byte(byte_t b);
        if (reply_open)
        begin
            work_items++;
            reply_bytes++;
            reply_pos++;
            if (reply_pos >= reply_len)
            begin
                reply_open = 1'b0;
            end
        end
        else
        begin
            ignored++;
        end
        push_item(1'b1, pack_item(byte_t'($urandom), 3'($urandom), 16'($urandom),
                                  11'($urandom), 1'($urandom), b));
    endtask

    // well-formed reply for the open request, optionally damaged or cut short
    task automatic send_reply(int corrupt_at, int stop_after);
        byte_t       rb[$];
        logic [15:0] crc;
        if (!reply_open)
        begin
            return;
        end
        if (tx_frame[1] == {5'd0, FC_FORCE_COIL})
        begin
            foreach (tx_frame[i])
            begin
                rb.push_back(tx_frame[i]);
            end
        end
        else
        begin
            rb.push_back(tx_frame[0]);
            rb.push_back(tx_frame[1]);
            rb.push_back(byte_t'(reply_len - 5));
            while (rb.size() < reply_len - 2)
            begin
                rb.push_back(byte_t'($urandom));
            end
            crc = CRC_INIT;
            foreach (rb[i])
            begin
                crc = crc_byte(crc, rb[i]);
            end
            rb.push_back(crc[7:0]);
            rb.push_back(crc[15:8]);
        end
        if (corrupt_at >= 0 && corrupt_at < rb.size())
        begin
            rb[corrupt_at] ^= byte_t'($urandom_range(1, 255));
        end
        for (int i = 0; i < rb.size() && i < stop_after; i++)
        begin
            send_reply_byte(rb[i]);
        end
    endtask

    // hold the sender until every predicted transfer has come out
    task automatic wait_drained();
        if (s_tvalid)
        begin
            s_tvalid <= 1'b0;
        end
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    // receiver with random stalls, none in steady stretches
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!rst_n)
            begin
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 5) == 0)
            begin
                stall_left = pause_len() - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("[rtu_master_frame_builder_checker_top] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int       r;
        int       next_break;
        logic [2:0] fc;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: stray reply byte, invalid functions
        send_reply_byte(8'hFF);
        send_request(8'h00, 3'd0, 16'h0000, 11'd0, 1'b0);
        send_request(8'hFF, 3'd6, 16'hFFFF, 11'd2047, 1'b1);
        send_request(8'hA5, 3'd7, 16'h5A5A, 11'd1024, 1'b0);
        // force coil on, extreme fields, clean echo
        send_request(8'hFF, FC_FORCE_COIL, 16'hFFFF, 11'd2047, 1'b1);
        send_reply(-1, 8);
        // saturating read abandoned by a new request
        send_request(8'h01, FC_READ_HOLDING, 16'h0000, 11'd2047, 1'b0);
        // one register, crc low byte damaged
        send_request(8'h11, FC_READ_INPUT_REGS, 16'h8000, 11'd1, 1'b0);
        send_reply(reply_len - 2, 300);
        // discrete inputs, reply cut after three bytes
        send_request(8'h7F, FC_READ_INPUTS, 16'h00FF, 11'd9, 1'b1);
        send_reply(-1, 3);
        // zero coils: no payload, status only
        send_request(8'h00, FC_READ_COILS, 16'h0000, 11'd0, 1'b0);
        send_reply(-1, 300);
        wait_drained();

        // one reply at the saturated length
        send_request(byte_t'($urandom), FC_READ_COILS, 16'($urandom), 11'd2047, 1'b0);
        send_reply(-1, 300);
        wait_drained();

        // random sequences, mostly well formed, until the item budget is spent
        next_break = work_items + ignored + 60;
        while (work_items + ignored < TARGET_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                fc = 3'($urandom_range(1, 5));
                send_request(byte_t'($urandom), fc, 16'($urandom), pick_quantity(fc),
                             1'($urandom));
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    send_reply(-1, 300);
                end
                else if (r < 82)
                begin
                    send_reply($urandom_range(0, reply_len - 1), 300);
                end
                else if (r < 94)
                begin
                    send_reply(-1, $urandom_range(0, reply_len - 1));
                end
                else
                begin
                    send_reply(-1, 300);
                    repeat ($urandom_range(1, 3)) send_reply_byte(byte_t'($urandom));
                end
            end
            else if (r < 90)
            begin
                r = $urandom_range(0, 2);
                fc = (r == 0) ? 3'd0 : ((r == 1) ? 3'd6 : 3'd7);
                send_request(byte_t'($urandom), fc, 16'($urandom), 11'($urandom),
                             1'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send_reply_byte(byte_t'($urandom));
            end
            if (work_items + ignored >= next_break)
            begin
                wait_drained();
                steady = ($urandom_range(0, 2) == 0);
                next_break += 60;
            end
        end

        // drain and settle
        steady = 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);

        $display("run covered %0d requests and %0d reply bytes (%0d ignored items)",
                 requests, reply_bytes, ignored);
        $display("%0d results matched, %0d mismatches, %0d results still expected",
                 checked, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("[rtu_master_frame_builder_checker_top] OK");
        end
        else
        begin
            $display("[rtu_master_frame_builder_checker_top] ERROR");
        end
        $finish;
    end

endmodule

>>> rtu_master_frame_builder_checker_top.f
src/rtumfb_pkg.sv
src/rtumfb_out.sv
src/rtu_master_frame_builder_checker_top.sv
tb/sv/rtu_frame_checker.sv
tb/sv/tb_rtu_master_frame_builder_checker_top.sv
